>>> sv/ffl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_pkg
// Shared types and constants of the first-fit free list unit: transaction
// payloads, action and status codes, controller to datapath signal groups.
// ----------------------------------------------------------------------------
package ffl_pkg;

   localparam int POS_W  = 12;
   localparam int SIZE_W = 13;

   localparam logic [SIZE_W-1:0] MIN_FREE_RESET = 13'd8;

   typedef enum logic [1:0] {
      ACT_FIND   = 2'd0,
      ACT_ADD    = 2'd1,
      ACT_SHRINK = 2'd2,
      ACT_REMOVE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_SHORT     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RES_OK    = 2'd0,
      RES_FOUND = 2'd1,
      RES_MISS  = 2'd2,
      RES_SHORT = 2'd3
   } res_type;

   typedef struct packed {
      action_type        action;
      logic [POS_W-1:0]  position;
      logic [SIZE_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] block_position;
      status_type       status;
   } rsp_type;

   typedef struct packed {
      logic    load_item;
      logic    advance;
      logic    do_add;
      logic    unlink;
      logic    split;
      logic    link_prev;
      logic    res_set;
      res_type res_sel;
      logic    rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      action_type action;
      logic       pos_ok;
      logic       walk_end;
      logic       cur_is_pos;
      logic       fits;
      logic       exact;
      logic       short_rem;
      logic       prev_zero;
   } dp_stat_type;

endpackage

>>> sv/ffl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffl_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/ffl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_ctrl
// Controller of the free list unit: sequences list walks, updates and
// the response register handshake.
// ----------------------------------------------------------------------------
module ffl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ffl_pkg::dp_stat_type stat,
   output ffl_pkg::dp_cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_ADD      = 9'b000000010,
      S_WALK     = 9'b000000100,
      S_CHECK    = 9'b000001000,
      S_LOC      = 9'b000010000,
      S_LOC_WAIT = 9'b000100000,
      S_APPLY    = 9'b001000000,
      S_LINK     = 9'b010000000,
      S_RESP     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_sel = ffl_pkg::RES_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = S_LOC;
            end
         end
         S_ADD: begin
            cmd.res_set = 1'b1;
            if (stat.pos_ok) begin
               cmd.do_add  = 1'b1;
               cmd.res_sel = ffl_pkg::RES_OK;
            end else begin
               cmd.res_sel = ffl_pkg::RES_MISS;
            end
            state_in = S_RESP;
         end
         S_WALK: begin
            if (stat.walk_end) begin
               cmd.res_set = 1'b1;
               cmd.res_sel = ffl_pkg::RES_MISS;
               state_in = S_RESP;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.fits) begin
               cmd.res_set = 1'b1;
               cmd.res_sel = ffl_pkg::RES_FOUND;
               state_in = S_RESP;
            end else begin
               cmd.advance = 1'b1;
               state_in = S_WALK;
            end
         end
         S_LOC: begin
            if (stat.action == ffl_pkg::ACT_FIND) begin
               state_in = S_WALK;
            end else if (stat.action == ffl_pkg::ACT_ADD) begin
               state_in = S_ADD;
            end else if (!stat.pos_ok || stat.walk_end) begin
               cmd.res_set = 1'b1;
               cmd.res_sel = ffl_pkg::RES_MISS;
               state_in = S_RESP;
            end else if (stat.cur_is_pos) begin
               state_in = S_APPLY;
            end else begin
               state_in = S_LOC_WAIT;
            end
         end
         S_LOC_WAIT: begin
            cmd.advance = 1'b1;
            state_in = S_LOC;
         end
         S_APPLY: begin
            cmd.res_set = 1'b1;
            if (stat.action == ffl_pkg::ACT_REMOVE || stat.exact) begin
               cmd.unlink  = 1'b1;
               cmd.res_sel = ffl_pkg::RES_OK;
               state_in = stat.prev_zero ? S_RESP : S_LINK;
            end else if (stat.short_rem) begin
               cmd.res_sel = ffl_pkg::RES_SHORT;
               state_in = S_RESP;
            end else begin
               cmd.split   = 1'b1;
               cmd.res_sel = ffl_pkg::RES_OK;
               state_in = stat.prev_zero ? S_RESP : S_LINK;
            end
         end
         S_LINK: begin
            cmd.link_prev = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/ffl_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_dpath
// Datapath of the free list unit: list head, walk registers, link and
// size memories, fit and split checks, result and response registers.
// ----------------------------------------------------------------------------
module ffl_dpath #(
   parameter int PAGE_BYTES = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ffl_pkg::SIZE_W-1:0]         csr_wdata,
   input  ffl_pkg::req_type                   req_data,
   input  ffl_pkg::dp_cmd_type                cmd,
   output ffl_pkg::dp_stat_type               stat,
   output ffl_pkg::rsp_type                   rsp_data
);

   localparam int ADDR_W = $clog2(PAGE_BYTES);
   localparam int STEP_W = $clog2(PAGE_BYTES + 1);
   localparam int CMP_W  = (STEP_W > 14) ? STEP_W : 14;
   localparam int POS_W  = ffl_pkg::POS_W;
   localparam int SIZE_W = ffl_pkg::SIZE_W;

   ffl_pkg::req_type  item_ff;
   ffl_pkg::rsp_type  res_ff;
   ffl_pkg::rsp_type  rsp_ff;
   logic [SIZE_W-1:0] min_free_ff;
   logic [POS_W-1:0]  head_ff;
   logic [POS_W-1:0]  cur_ff;
   logic [POS_W-1:0]  prev_ff;
   logic [POS_W-1:0]  link_val_ff;
   logic [STEP_W-1:0] steps_ff;

   logic [POS_W-1:0]  link_rd;
   logic [SIZE_W-1:0] size_rd;
   logic [13:0]       split_sum;
   logic [SIZE_W-1:0] remain;
   logic [13:0]       need;

   logic              link_we;
   logic [POS_W-1:0]  link_waddr;
   logic [POS_W-1:0]  link_wdata;
   logic              size_we;
   logic [POS_W-1:0]  size_waddr;
   logic [SIZE_W-1:0] size_wdata;

   assign split_sum = {2'b00, item_ff.position} + {1'b0, item_ff.amount};
   assign remain    = size_rd - item_ff.amount;
   assign need      = {1'b0, item_ff.amount} + {1'b0, min_free_ff};

   assign stat.action     = item_ff.action;
   assign stat.pos_ok     = (item_ff.position != '0) &&
                            (CMP_W'(item_ff.position) < CMP_W'(PAGE_BYTES));
   assign stat.walk_end   = (cur_ff == '0) || (steps_ff == STEP_W'(PAGE_BYTES));
   assign stat.cur_is_pos = (cur_ff == item_ff.position);
   assign stat.fits       = (need <= {1'b0, size_rd}) || (item_ff.amount == size_rd);
   assign stat.exact      = (item_ff.amount == size_rd);
   assign stat.short_rem  = (item_ff.amount > size_rd) || (remain < min_free_ff) ||
                            (CMP_W'(split_sum) >= CMP_W'(PAGE_BYTES)) ||
                            (split_sum[13:12] != 2'b00);
   assign stat.prev_zero  = (prev_ff == '0);

   always_comb begin
      link_we    = cmd.do_add || cmd.split || cmd.link_prev;
      link_waddr = prev_ff;
      link_wdata = link_val_ff;
      if (cmd.do_add) begin
         link_waddr = item_ff.position;
         link_wdata = head_ff;
      end else if (cmd.split) begin
         link_waddr = split_sum[POS_W-1:0];
         link_wdata = link_rd;
      end
   end

   always_comb begin
      size_we    = cmd.do_add || cmd.split;
      size_waddr = split_sum[POS_W-1:0];
      size_wdata = remain;
      if (cmd.do_add) begin
         size_waddr = item_ff.position;
         size_wdata = item_ff.amount;
      end
   end

   ffl_ram #(
      .WIDTH (POS_W),
      .DEPTH (PAGE_BYTES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (ADDR_W'(link_waddr)),
      .wr_data (link_wdata),
      .rd_addr (ADDR_W'(cur_ff)),
      .rd_data (link_rd)
   );

   ffl_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (PAGE_BYTES)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (size_we),
      .wr_addr (ADDR_W'(size_waddr)),
      .wr_data (size_wdata),
      .rd_addr (ADDR_W'(cur_ff)),
      .rd_data (size_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         min_free_ff <= ffl_pkg::MIN_FREE_RESET;
      end else begin
         if (csr_we) begin
            min_free_ff <= csr_wdata;
         end
         if (cmd.do_add) begin
            head_ff <= item_ff.position;
         end else if (cmd.unlink && prev_ff == '0) begin
            head_ff <= link_rd;
         end else if (cmd.split && prev_ff == '0) begin
            head_ff <= split_sum[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff  <= req_data;
         cur_ff   <= head_ff;
         prev_ff  <= '0;
         steps_ff <= '0;
      end else if (cmd.advance) begin
         cur_ff   <= link_rd;
         prev_ff  <= cur_ff;
         steps_ff <= steps_ff + STEP_W'(1);
      end
      if (cmd.unlink) begin
         link_val_ff <= link_rd;
      end else if (cmd.split) begin
         link_val_ff <= split_sum[POS_W-1:0];
      end
      if (cmd.res_set) begin
         case (cmd.res_sel)
            ffl_pkg::RES_FOUND: res_ff <= '{1'b1, cur_ff, ffl_pkg::STAT_OK};
            ffl_pkg::RES_MISS:  res_ff <= '{1'b0, '0, ffl_pkg::STAT_NOT_FOUND};
            ffl_pkg::RES_SHORT: res_ff <= '{1'b0, '0, ffl_pkg::STAT_SHORT};
            default:            res_ff <= '{1'b0, '0, ffl_pkg::STAT_OK};
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> sv/first_fit_free_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_free_list_unit
// First-fit free list kept in a page: find, add, shrink and remove free
// blocks in a singly linked list held in link and size memories.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  ffl_pkg::req_type
// rsp_      out        rsp_valid / rsp_ready  ffl_pkg::rsp_type
// csr_      in         csr_we                 min_free_size, 13 bits
//
// One transaction at a time, from acceptance back to idle. Find walks the
// list from the head, reading and checking each node in turn; shrink and
// remove walk to the block, then apply the change and, unless the block is
// the head, rewrite the predecessor link; add links the block in at the head.
// Each node visit waits for the registered memory read. Reset empties the list.
// A finished transaction holds until the previous response has drained.
// ----------------------------------------------------------------------------
module first_fit_free_list_unit #(
   parameter int PAGE_BYTES = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ffl_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ffl_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [ffl_pkg::SIZE_W-1:0] csr_wdata
);

   ffl_pkg::dp_cmd_type  cmd;
   ffl_pkg::dp_stat_type stat;

   ffl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffl_dpath #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sv/ffl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_checker
// Port-level checks of the first-fit free list unit, bound to the top.
// ----------------------------------------------------------------------------
module ffl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ffl_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while busy");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |->
         rsp_data.status == ffl_pkg::STAT_OK && rsp_data.block_position != '0)
      else $error("found block without ok status or at position zero");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.block_position == '0)
      else $error("position reported without a found block");

endmodule

bind first_fit_free_list_unit ffl_checker u_ffl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for first_fit_free_list_unit. A behavioral copy of the
// free list predicts every response. Directed tests come first: the empty
// list, bad positions, fit rules, shrink corner cases and min_free_size
// extremes. Random allocator-like traffic follows under several minimum
// sizes. A final test closes the list into a loop to exercise bounded walks.
// Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int PAGE     = 4096;
   localparam int POS_MAX  = 4095;
   localparam int LIST_CAP = 24;
   localparam int POS_W    = ffl_pkg::POS_W;
   localparam int SIZE_W   = ffl_pkg::SIZE_W;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ffl_pkg::req_type  req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ffl_pkg::rsp_type  rsp_data;
   logic              csr_we    = 1'b0;
   logic [SIZE_W-1:0] csr_wdata = ffl_pkg::MIN_FREE_RESET;

   first_fit_free_list_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   int              fl_head     = 0;
   int              fl_min_free = int'(ffl_pkg::MIN_FREE_RESET);
   bit [POS_W-1:0]  fl_link [PAGE];
   bit [SIZE_W-1:0] fl_size [PAGE];

   ffl_pkg::rsp_type predicted_outcomes [$];
   ffl_pkg::rsp_type want;

   int mismatch_count = 0;
   int items_sent     = 0;
   int settings_used  = 0;
   int action_count [4];
   bit req_idle_on    = 1'b0;
   bit rsp_stall_on   = 1'b0;

   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic ffl_pkg::req_type make_req(ffl_pkg::action_type act, int pos,
                                                 int amt);
      ffl_pkg::req_type item;
      item.action   = act;
      item.position = POS_W'(pos);
      item.amount   = SIZE_W'(amt);
      return item;
   endfunction

   function automatic bit locate_block(int pos, output int prev);
      int cur;
      int behind;
      int steps;
      cur    = fl_head;
      behind = 0;
      steps  = 0;
      prev   = 0;
      while (cur != 0 && steps < PAGE) begin
         if (cur == pos) begin
            prev = behind;
            return 1'b1;
         end
         behind = cur;
         cur    = fl_link[cur];
         steps++;
      end
      return 1'b0;
   endfunction

   function automatic void unlink_block(int pos, int prev);
      if (prev == 0) begin
         fl_head = fl_link[pos];
      end else begin
         fl_link[prev] = fl_link[pos];
      end
   endfunction

   function automatic ffl_pkg::rsp_type predict_free_list(ffl_pkg::req_type item);
      ffl_pkg::rsp_type res;
      int               pos;
      int               amt;
      int               cur;
      int               steps;
      int               prev;
      int               sz;
      int               split;
      res        = '0;
      res.status = ffl_pkg::STAT_OK;
      pos        = item.position;
      amt        = item.amount;
      prev       = 0;
      case (item.action)
         ffl_pkg::ACT_FIND: begin
            res.status = ffl_pkg::STAT_NOT_FOUND;
            cur        = fl_head;
            steps      = 0;
            while (cur != 0 && steps < PAGE) begin
               sz = fl_size[cur];
               if (amt + fl_min_free <= sz || amt == sz) begin
                  res.found          = 1'b1;
                  res.block_position = POS_W'(cur);
                  res.status         = ffl_pkg::STAT_OK;
                  break;
               end
               cur = fl_link[cur];
               steps++;
            end
         end
         ffl_pkg::ACT_ADD: begin
            if (pos == 0) begin
               res.status = ffl_pkg::STAT_NOT_FOUND;
            end else begin
               fl_size[pos] = item.amount;
               fl_link[pos] = POS_W'(fl_head);
               fl_head      = pos;
            end
         end
         default: begin
            if (pos == 0 || !locate_block(pos, prev)) begin
               res.status = ffl_pkg::STAT_NOT_FOUND;
            end else if (item.action == ffl_pkg::ACT_REMOVE) begin
               unlink_block(pos, prev);
            end else begin
               sz    = fl_size[pos];
               split = pos + amt;
               if (amt == sz) begin
                  unlink_block(pos, prev);
               end else if (amt > sz || sz - amt < fl_min_free ||
                            split > POS_MAX) begin
                  res.status = ffl_pkg::STAT_SHORT;
               end else begin
                  fl_size[split] = SIZE_W'(sz - amt);
                  fl_link[split] = fl_link[pos];
                  if (prev == 0) begin
                     fl_head = split;
                  end else begin
                     fl_link[prev] = POS_W'(split);
                  end
               end
            end
         end
      endcase
      return res;
   endfunction

   function automatic bit is_listed(int nodes [$], int p);
      foreach (nodes[i]) begin
         if (nodes[i] == p) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Mostly well-formed allocator traffic; never closes the list into a loop.
   function automatic ffl_pkg::req_type next_random_item();
      int                  nodes [$];
      int                  cur;
      int                  steps;
      int                  pick;
      int                  pos;
      int                  amt;
      int                  sz;
      int                  split;
      int                  roll;
      ffl_pkg::action_type act;
      cur   = fl_head;
      steps = 0;
      while (cur != 0 && steps < PAGE) begin
         nodes.push_back(cur);
         cur = fl_link[cur];
         steps++;
      end
      roll = $urandom_range(0, 99);
      if ((nodes.size() < 3 && roll < 60) ||
          (nodes.size() < LIST_CAP && roll < 28)) begin
         act = ffl_pkg::ACT_ADD;
      end else if (roll < 52) begin
         act = ffl_pkg::ACT_FIND;
      end else if (roll < 78) begin
         act = ffl_pkg::ACT_SHRINK;
      end else begin
         act = ffl_pkg::ACT_REMOVE;
      end
      pos  = 0;
      amt  = 0;
      pick = 0;
      sz   = 0;
      if (nodes.size() > 0) begin
         pick = nodes[$urandom_range(0, nodes.size() - 1)];
         sz   = fl_size[pick];
      end
      case (act)
         ffl_pkg::ACT_ADD: begin
            if ($urandom_range(0, 29) == 0) begin
               pos = 0;
            end else begin
               do pos = $urandom_range(1, POS_MAX); while (is_listed(nodes, pos));
            end
            case ($urandom_range(0, 9))
               0:       amt = $urandom_range(0, 1) ? 0 : PAGE;
               1, 2:    amt = $urandom_range(600, PAGE);
               3, 4, 5: amt = $urandom_range(64, 599);
               default: amt = $urandom_range(1, 63);
            endcase
         end
         ffl_pkg::ACT_FIND: begin
            if (pick != 0 && $urandom_range(0, 9) < 7) begin
               case ($urandom_range(0, 3))
                  0:       amt = sz;
                  1:       amt = sz - fl_min_free;
                  2:       amt = sz - fl_min_free + 1;
                  default: amt = $urandom_range(0, sz);
               endcase
            end else begin
               amt = $urandom_range(0, PAGE);
            end
         end
         default: begin
            if (pick != 0 && $urandom_range(0, 9) < 8) begin
               pos = pick;
            end else begin
               pos = $urandom_range(0, POS_MAX);
            end
            if (act == ffl_pkg::ACT_SHRINK) begin
               if (is_listed(nodes, pos)) begin
                  sz = fl_size[pos];
               end else begin
                  sz = $urandom_range(0, 64);
               end
               case ($urandom_range(0, 5))
                  0:       amt = 0;
                  1:       amt = sz;
                  2:       amt = sz - fl_min_free;
                  3:       amt = sz - fl_min_free + 1;
                  4:       amt = sz + 1;
                  default: amt = $urandom_range(0, sz);
               endcase
               if (amt < 0) amt = 0;
               if (amt > PAGE) amt = PAGE;
               split = pos + amt;
               if (is_listed(nodes, pos) && amt < sz && sz - amt >= fl_min_free &&
                   split <= POS_MAX && split != pos && is_listed(nodes, split)) begin
                  amt = sz;
               end
            end
         end
      endcase
      if (amt < 0) amt = 0;
      if (amt > PAGE) amt = PAGE;
      return make_req(act, pos, amt);
   endfunction

   task automatic report_error(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   task automatic send_item(ffl_pkg::req_type item);
      int gap;
      gap = (req_idle_on && $urandom_range(0, 1)) ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predicted_outcomes.push_back(predict_free_list(item));
      items_sent++;
      action_count[int'(item.action)]++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (predicted_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_min_free(int value);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_wdata <= SIZE_W'(value);
      @(posedge clock);
      csr_we      <= 1'b0;
      fl_min_free = value;
      settings_used++;
   endtask

   task automatic test_empty_list_and_bad_positions();
      req_idle_on  = 1'b1;
      rsp_stall_on = 1'b1;
      send_item(make_req(ffl_pkg::ACT_FIND, 0, 0));
      send_item(make_req(ffl_pkg::ACT_ADD, 0, 16));
      send_item(make_req(ffl_pkg::ACT_REMOVE, 5, 0));
      send_item(make_req(ffl_pkg::ACT_SHRINK, 5, 3));
   endtask

   task automatic test_find_and_shrink_cases();
      send_item(make_req(ffl_pkg::ACT_ADD, POS_MAX, PAGE));
      send_item(make_req(ffl_pkg::ACT_ADD, 1, 0));
      send_item(make_req(ffl_pkg::ACT_ADD, 2048, 100));
      send_item(make_req(ffl_pkg::ACT_FIND, 0, PAGE));
      send_item(make_req(ffl_pkg::ACT_FIND, 0, 0));
      send_item(make_req(ffl_pkg::ACT_FIND, 0, 93));
      send_item(make_req(ffl_pkg::ACT_SHRINK, 2048, 0));
      send_item(make_req(ffl_pkg::ACT_SHRINK, 2048, 101));
      send_item(make_req(ffl_pkg::ACT_SHRINK, 2048, 95));
      send_item(make_req(ffl_pkg::ACT_SHRINK, 2048, 50));
      send_item(make_req(ffl_pkg::ACT_SHRINK, 1, 0));
      send_item(make_req(ffl_pkg::ACT_SHRINK, POS_MAX, 1));
      send_item(make_req(ffl_pkg::ACT_SHRINK, POS_MAX, PAGE));
      send_item(make_req(ffl_pkg::ACT_REMOVE, 2098, 0));
      send_item(make_req(ffl_pkg::ACT_FIND, 0, 0));
   endtask

   task automatic test_min_free_size();
      set_min_free(1);
      send_item(make_req(ffl_pkg::ACT_ADD, 10, 10));
      send_item(make_req(ffl_pkg::ACT_FIND, 0, 9));
      set_min_free(PAGE);
      send_item(make_req(ffl_pkg::ACT_FIND, 0, 0));
      send_item(make_req(ffl_pkg::ACT_FIND, 0, 10));
      send_item(make_req(ffl_pkg::ACT_REMOVE, 10, 0));
      set_min_free(int'(ffl_pkg::MIN_FREE_RESET));
   endtask

   task automatic test_random_traffic(int count, bit idle);
      req_idle_on  = idle;
      rsp_stall_on = idle;
      for (int i = 0; i < count; i++) begin
         send_item(next_random_item());
         if ($urandom_range(0, 49) == 0) wait_for_results();
      end
   endtask

   // Adding a block twice makes it point at itself; walks must give up.
   task automatic test_circular_list();
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b1;
      send_item(make_req(ffl_pkg::ACT_ADD, 7, 20));
      send_item(make_req(ffl_pkg::ACT_ADD, 7, 20));
      send_item(make_req(ffl_pkg::ACT_FIND, 0, 100));
      send_item(make_req(ffl_pkg::ACT_REMOVE, 9, 0));
      send_item(make_req(ffl_pkg::ACT_FIND, 0, 20));
   endtask

   initial begin
      forever begin
         if (rsp_stall_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_length()) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_outcomes.size() == 0) begin
            report_error($sformatf(
               "unexpected response: found=%0d block_position=%0d status=%0d",
               rsp_data.found, rsp_data.block_position, rsp_data.status));
         end else begin
            want = predicted_outcomes.pop_front();
            if (rsp_data.found !== want.found ||
                rsp_data.block_position !== want.block_position ||
                rsp_data.status !== want.status) begin
               report_error($sformatf(
                  {"mismatch: expected found=%0d pos=%0d status=%0d,",
                   " got found=%0d pos=%0d status=%0d"},
                  want.found, want.block_position, want.status,
                  rsp_data.found, rsp_data.block_position, rsp_data.status));
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      foreach (action_count[i]) action_count[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_list_and_bad_positions();
      test_find_and_shrink_cases();
      test_min_free_size();
      test_random_traffic(130, 1'b0);
      set_min_free(1);
      test_random_traffic(130, 1'b1);
      set_min_free(PAGE);
      test_random_traffic(60, 1'b1);
      set_min_free($urandom_range(2, 300));
      test_random_traffic(200, 1'b1);
      set_min_free(int'(ffl_pkg::MIN_FREE_RESET));
      test_random_traffic(130, 1'b1);
      test_circular_list();
      wait_for_results();
      repeat (20) @(posedge clock);
      $display("Covered %0d transactions (find %0d, add %0d, shrink %0d, remove %0d)",
               items_sent, action_count[0], action_count[1], action_count[2],
               action_count[3]);
      $display("Included %0d csr writes, off-page splits, exact shrinks, a looped list",
               settings_used);
      $display("and stalls; %0d errors", mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
